FILE: src/ihb_pkg.sv
// ----------------------------------------------------------------------------
// ihb_pkg
// Shared types, constants and helpers for the IPv4 header builder.
// ----------------------------------------------------------------------------
package ihb_pkg;

    // header constants
    localparam logic [15:0] HDR_BYTES   = 16'd20;
    localparam logic [15:0] MAX_PAYLOAD = 16'd65515;
    localparam logic [15:0] ID_BASE     = 16'd1234;
    localparam logic [7:0]  TTL_RESET   = 8'd64;
    localparam logic [7:0]  VER_IHL     = 8'h45;
    localparam logic [7:0]  TOS_VALUE   = 8'h00;

    // word numbers within the header
    localparam logic [2:0] W_VER_LEN  = 3'd0;
    localparam logic [2:0] W_IDENT    = 3'd1;
    localparam logic [2:0] W_TTL_CSUM = 3'd2;
    localparam logic [2:0] W_SRC      = 3'd3;
    localparam logic [2:0] W_DST      = 3'd4;

    // request as classified by the front part, with the raw halfword sum
    typedef struct packed {
        logic [15:0] total_length;
        logic [15:0] ident;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [31:0] src;
        logic [31:0] dst;
        logic [19:0] raw_sum;
    } t_req;

    // request ready to be emitted, checksum folded
    typedef struct packed {
        logic [15:0] total_length;
        logic [15:0] ident;
        logic [7:0]  ttl;
        logic [7:0]  protocol;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] csum;
    } t_hdr;

    // queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

    // fold the halfword sum twice and complement it
    function automatic logic [15:0] fold_csum(input logic [19:0] s);
        logic [16:0] t;
        logic [16:0] u;
        t = {13'd0, s[19:16]} + {1'b0, s[15:0]};
        u = {16'd0, t[16]} + {1'b0, t[15:0]};
        return ~u[15:0];
    endfunction

    // convert a queued request into its emit form
    function automatic t_hdr to_hdr(input t_req r);
        t_hdr h;
        h.total_length = r.total_length;
        h.ident        = r.ident;
        h.ttl          = r.ttl;
        h.protocol     = r.protocol;
        h.src          = r.src;
        h.dst          = r.dst;
        h.csum         = fold_csum(r.raw_sum);
        return h;
    endfunction

    // pick one header word
    function automatic logic [31:0] hdr_word(input t_hdr h, input logic [2:0] idx);
        logic [31:0] w;
        case (idx)
            W_VER_LEN:  w = {VER_IHL, TOS_VALUE, h.total_length};
            W_IDENT:    w = {h.ident, 16'h0000};
            W_TTL_CSUM: w = {h.ttl, h.protocol, h.csum};
            W_SRC:      w = h.src;
            W_DST:      w = h.dst;
            default:    w = 32'h0000_0000;
        endcase
        return w;
    endfunction

endpackage

FILE: src/ihb_if.sv
// ----------------------------------------------------------------------------
// ihb_if
// Valid/ready channels of the IPv4 header builder: requests and header words.
// ----------------------------------------------------------------------------
interface ihb_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] payload_length;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [31:0] destination_address;

    modport source (
        output valid, payload_length, protocol_number, source_address,
               destination_address,
        input  ready
    );
    modport sink (
        input  valid, payload_length, protocol_number, source_address,
               destination_address,
        output ready
    );
endinterface

interface ihb_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] header_word;
    logic [2:0]  word_number;
    logic        last_word;

    modport source (
        output valid, header_word, word_number, last_word,
        input  ready
    );
    modport sink (
        input  valid, header_word, word_number, last_word,
        output ready
    );
endinterface

FILE: src/ipv4_header_builder_unit.sv
// ----------------------------------------------------------------------------
// ipv4_header_builder_unit
// Builds a 20-byte IPv4 header with its checksum for each request and sends
// it as five 32-bit words in network byte order.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      beat contents
//  i_req     in   valid/ready    payload length, protocol, src, dst addresses
//  o_word    out  valid/ready    header word, word number, last word flag
//  cfg       in   i_cfg_we       ttl value on i_cfg_wdata
//
//  each request yields five output beats, one per cycle while o_word is ready;
//  the rate is set by the single 32-bit output word register
//  a taken request reaches o_word through the queue, the current-header
//  register and the output register; the queue holds QUEUE_DEPTH requests ahead of it
//  reset is synchronous, active low; ttl returns to 64, identification to 1234
//  a stalled output keeps its beat; requests keep flowing until the queue fills
// ----------------------------------------------------------------------------
module ipv4_header_builder_unit
    import ihb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    ihb_req_if.sink    i_req,
    ihb_word_if.source o_word
);

    t_q_stat q_stat;
    t_req    q_wdata;
    t_req    q_rdata;
    logic    q_push;
    logic    q_pop;

    // request intake
    ihb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_q_stat    (q_stat),
        .o_push      (q_push),
        .o_entry     (q_wdata)
    );

    // decoupling queue
    ihb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_stat  (q_stat),
        .o_data  (q_rdata)
    );

    // word emitter
    ihb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_q_data (q_rdata),
        .o_pop    (q_pop),
        .o_word   (o_word)
    );

    // last flag only on the final word
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word.valid |-> (o_word.last_word == (o_word.word_number == W_DST)))
        else $error("last word flag out of place");

    // words of one header follow without a gap
    a_word_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.valid && o_word.ready && !o_word.last_word) |=>
        (o_word.valid && (o_word.word_number == $past(o_word.word_number) + 3'd1)))
        else $error("header words out of sequence");

    // never write a full queue, never read an empty one
    a_q_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_stat.full) && !(q_pop && !q_stat.valid))
        else $error("queue overflow or underflow");

    // a new header starts only at word zero
    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_word.valid && o_word.ready && o_word.last_word) |=>
        (!o_word.valid || (o_word.word_number == W_VER_LEN)))
        else $error("header did not restart at word zero");

endmodule

FILE: src/ihb_front.sv
// ----------------------------------------------------------------------------
// ihb_front
// Accepts requests, fills in length, identification and TTL, and sums the
// header halfwords before handing the request to the queue.
// ----------------------------------------------------------------------------
module ihb_front
    import ihb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    ihb_req_if.sink     i_req,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_req        o_entry
);

    logic [7:0]  r_ttl;
    logic [15:0] r_id_cnt;
    logic [15:0] pay_sat;
    logic [15:0] ttl_proto;

    // take a beat whenever the queue has room
    assign i_req.ready = !i_q_stat.full;
    assign o_push      = i_req.valid && !i_q_stat.full;

    // classify the request
    always_comb begin
        pay_sat = (i_req.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                       : i_req.payload_length;
        ttl_proto = {r_ttl, i_req.protocol_number};

        o_entry.total_length = HDR_BYTES + pay_sat;
        o_entry.ident        = ID_BASE + r_id_cnt;
        o_entry.ttl          = r_ttl;
        o_entry.protocol     = i_req.protocol_number;
        o_entry.src          = i_req.source_address;
        o_entry.dst          = i_req.destination_address;
        o_entry.raw_sum      = {4'd0, VER_IHL, TOS_VALUE}
                             + {4'd0, o_entry.total_length}
                             + {4'd0, o_entry.ident}
                             + {4'd0, ttl_proto}
                             + {4'd0, i_req.source_address[31:16]}
                             + {4'd0, i_req.source_address[15:0]}
                             + {4'd0, i_req.destination_address[31:16]}
                             + {4'd0, i_req.destination_address[15:0]};
    end

    // ttl register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl <= TTL_RESET;
        end else if (i_cfg_we) begin
            r_ttl <= i_cfg_wdata;
        end
    end

    // identification counter, wraps at 16 bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_cnt <= 16'd0;
        end else if (o_push) begin
            r_id_cnt <= r_id_cnt + 16'd1;
        end
    end

endmodule

FILE: src/ihb_fifo.sv
// ----------------------------------------------------------------------------
// ihb_fifo
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module ihb_fifo
    import ihb_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_req    i_data,
    input  logic    i_pop,
    output t_q_stat o_stat,
    output t_req    o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_req             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.valid = (r_count != '0);
    assign o_data       = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: src/ihb_back.sv
// ----------------------------------------------------------------------------
// ihb_back
// Folds the checksum and emits the five header words, one beat per cycle while the sink is ready.
// ----------------------------------------------------------------------------
module ihb_back
    import ihb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_stat    i_q_stat,
    input  t_req       i_q_data,
    output logic       o_pop,
    ihb_word_if.source o_word
);

    t_hdr        r_cur;
    logic        r_busy;
    logic [2:0]  r_idx;
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic [2:0]  r_out_num;
    logic        r_out_last;
    logic        advance;
    logic        done_cur;

    assign o_word.valid       = r_out_valid;
    assign o_word.header_word = r_out_word;
    assign o_word.word_number = r_out_num;
    assign o_word.last_word   = r_out_last;

    // output register free or draining this cycle
    assign advance  = !r_out_valid || o_word.ready;
    assign done_cur = !r_busy || (r_idx == W_DST);
    assign o_pop    = advance && done_cur && i_q_stat.valid;

    // current request and word index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= W_VER_LEN;
        end else if (advance) begin
            if (done_cur) begin
                r_busy <= i_q_stat.valid;
                r_idx  <= W_VER_LEN;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= to_hdr(i_q_data);
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_busy) begin
            r_out_word <= hdr_word(r_cur, r_idx);
            r_out_num  <= r_idx;
            r_out_last <= (r_idx == W_DST);
        end
    end

endmodule
